// ===== rtl/linked_line_table_top_defines.svh =====
// assertion macros for the linked line table
// used by linked_line_table_top; expects clk and rst_n in scope
`ifndef LINKED_LINE_TABLE_TOP_DEFINES_SVH
`define LINKED_LINE_TABLE_TOP_DEFINES_SVH

// same-cycle implication, checked outside reset
`define LLT_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked outside reset
`define LLT_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== rtl/llt_pkg.sv =====
// types and codes for the linked line table
// no dependencies
`timescale 1ns / 1ps

package llt_pkg;

  typedef enum logic {
    OP_INSERT = 1'b0,
    OP_DELETE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_FULL    = 2'd1,
    ST_IGNORED = 2'd2
  } status_t;

  localparam int FIELD_W = 7;
  localparam logic [FIELD_W-1:0] FIELD_NIL = 7'h7F;

endpackage

// ===== rtl/linked_line_table_top.sv =====
// linked line table: link arrays, head/tail pointers and bump allocator
// depends on llt_pkg and linked_line_table_top_defines.svh
`timescale 1ns / 1ps

// After reset, busy stays high while a clearing pass writes NIL into one entry
// of each link array per cycle, and no command is taken. After that, busy stays
// low and the block takes one command every cycle. Each command gives exactly
// one result. At the accepting edge the command and the target's two links are
// registered; the link read passes through any write made at that same edge. At
// the next edge the update is done and the result register is loaded. out_valid
// therefore rises with the result register and is high for a single cycle per
// result. The receiver cannot hold results off. Each update reads one address
// per link array and writes at most two entries of each array.
module linked_line_table_top #(
  parameter int ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  output logic       busy,
  input  logic       in_op,
  input  logic [6:0] in_target,
  output logic       out_valid,
  output logic [1:0] out_status,
  output logic [6:0] out_new_slot,
  output logic [6:0] out_head_out,
  output logic [6:0] out_tail_out
);

`include "linked_line_table_top_defines.svh"

  localparam int IDX_W = $clog2(ENTRIES);
  localparam int PW    = IDX_W + 1;
  localparam int CW    = (IDX_W > 6) ? IDX_W : 6;
  localparam int OW    = (IDX_W > llt_pkg::FIELD_W) ? IDX_W : llt_pkg::FIELD_W;
  localparam logic [PW-1:0] NIL = {1'b1, {IDX_W{1'b0}}};
  localparam logic [PW-1:0] FULL_CNT = PW'(ENTRIES);

  // command register and the target's links read with it
  logic             vld_r;
  llt_pkg::op_t     op_r;
  logic [6:0]       tgt_r;
  logic [PW-1:0]    rd_prev_r;
  logic [PW-1:0]    rd_next_r;

  // clearing pass after reset
  logic             clr_r;
  logic [IDX_W-1:0] clr_idx_r;

  // list state
  logic [PW-1:0]    head_r, head_nxt;
  logic [PW-1:0]    tail_r, tail_nxt;
  logic [PW-1:0]    used_r, used_nxt;
  logic [PW-1:0]    prev_mem [ENTRIES];
  logic [PW-1:0]    next_mem [ENTRIES];

  // result register
  logic             out_valid_r;
  llt_pkg::status_t out_status_r, status_nxt;
  logic [6:0]       out_new_slot_r;
  logic [6:0]       out_head_r;
  logic [6:0]       out_tail_r;

  // decode
  logic [CW-1:0]    in_wide;
  logic [IDX_W-1:0] in_idx;
  logic [CW-1:0]    tgt_wide;
  logic             in_tbl;
  logic [IDX_W-1:0] tgt_idx;
  logic [IDX_W-1:0] slot_idx;
  logic [PW-1:0]    tgt_ptr, slot_ptr;
  logic             full;
  logic [PW-1:0]    new_slot_nxt;

  // two write ports per array, port 1 wins on the same address
  logic             nw0_en, nw1_en, pw0_en, pw1_en;
  logic             nw0_go, pw0_go;
  logic [IDX_W-1:0] nw0_a, nw1_a, pw0_a, pw1_a;
  logic [PW-1:0]    nw0_d, nw1_d, pw0_d, pw1_d;

  function automatic logic [6:0] to_field(input logic [PW-1:0] p);
    logic [OW-1:0] w;
    w = OW'(p[IDX_W-1:0]);
    if (p[IDX_W]) begin
      return llt_pkg::FIELD_NIL;
    end
    return w[6:0];
  endfunction

  assign busy = clr_r;

  always_comb begin
    in_wide  = CW'(in_target[5:0]);
    in_idx   = in_wide[IDX_W-1:0];
    tgt_wide = CW'(tgt_r[5:0]);
    in_tbl   = !tgt_r[6] && ({1'b0, tgt_wide} < (CW + 1)'(ENTRIES));
    tgt_idx  = tgt_wide[IDX_W-1:0];
    tgt_ptr  = {1'b0, tgt_idx};
    slot_idx = used_r[IDX_W-1:0];
    slot_ptr = {1'b0, slot_idx};
    full     = (used_r == FULL_CNT);
  end

  always_comb begin
    head_nxt     = head_r;
    tail_nxt     = tail_r;
    used_nxt     = used_r;
    status_nxt   = llt_pkg::ST_DONE;
    new_slot_nxt = NIL;
    nw0_en = 1'b0; nw0_a = slot_idx; nw0_d = NIL;
    nw1_en = 1'b0; nw1_a = tgt_idx;  nw1_d = NIL;
    pw0_en = 1'b0; pw0_a = slot_idx; pw0_d = NIL;
    pw1_en = 1'b0; pw1_a = tgt_idx;  pw1_d = NIL;
    if (clr_r) begin
      nw0_en = 1'b1;
      nw0_a  = clr_idx_r;
      pw0_en = 1'b1;
      pw0_a  = clr_idx_r;
    end else if (vld_r) begin
      case (op_r)
        llt_pkg::OP_INSERT: begin
          if (full) begin
            status_nxt = llt_pkg::ST_FULL;
          end else begin
            new_slot_nxt = slot_ptr;
            used_nxt     = used_r + PW'(1);
            nw0_en = 1'b1;
            pw0_en = 1'b1;
            if (head_r[IDX_W]) begin
              head_nxt = slot_ptr;
              tail_nxt = slot_ptr;
            end else if (!in_tbl) begin
              // append at the tail; no forward link through an empty tail
              pw0_d    = tail_r;
              nw1_en   = !tail_r[IDX_W];
              nw1_a    = tail_r[IDX_W-1:0];
              nw1_d    = slot_ptr;
              tail_nxt = slot_ptr;
            end else begin
              nw0_d  = rd_next_r;
              pw0_d  = tgt_ptr;
              nw1_en = 1'b1;
              nw1_d  = slot_ptr;
              if (rd_next_r[IDX_W]) begin
                tail_nxt = slot_ptr;
              end else begin
                pw1_en = 1'b1;
                pw1_a  = rd_next_r[IDX_W-1:0];
                pw1_d  = slot_ptr;
              end
            end
          end
        end
        llt_pkg::OP_DELETE: begin
          if (!in_tbl) begin
            status_nxt = llt_pkg::ST_IGNORED;
          end else begin
            if (rd_prev_r[IDX_W]) begin
              head_nxt = rd_next_r;
            end else begin
              nw0_en = 1'b1;
              nw0_a  = rd_prev_r[IDX_W-1:0];
              nw0_d  = rd_next_r;
            end
            if (rd_next_r[IDX_W]) begin
              tail_nxt = rd_prev_r;
            end else begin
              pw0_en = 1'b1;
              pw0_a  = rd_next_r[IDX_W-1:0];
              pw0_d  = rd_prev_r;
            end
            // the target's own links are cleared last
            nw1_en = 1'b1;
            pw1_en = 1'b1;
          end
        end
        default: begin
          status_nxt = llt_pkg::ST_DONE;
        end
      endcase
    end
  end

  assign nw0_go = nw0_en && !(nw1_en && (nw1_a == nw0_a));
  assign pw0_go = pw0_en && !(pw1_en && (pw1_a == pw0_a));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= 1'b0;
      head_r      <= NIL;
      tail_r      <= NIL;
      used_r      <= '0;
      clr_r       <= 1'b1;
      clr_idx_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      vld_r       <= start && !busy;
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      used_r      <= used_nxt;
      out_valid_r <= vld_r;
      if (clr_r) begin
        clr_idx_r <= clr_idx_r + IDX_W'(1);
        if (clr_idx_r == IDX_W'(ENTRIES - 1)) clr_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    op_r  <= llt_pkg::op_t'(in_op);
    tgt_r <= in_target;
    if (nw0_go) next_mem[nw0_a] <= nw0_d;
    if (nw1_en) next_mem[nw1_a] <= nw1_d;
    if (pw0_go) prev_mem[pw0_a] <= pw0_d;
    if (pw1_en) prev_mem[pw1_a] <= pw1_d;
    // links of the incoming target, passing through this edge's writes
    if (nw1_en && (nw1_a == in_idx)) rd_next_r <= nw1_d;
    else if (nw0_en && (nw0_a == in_idx)) rd_next_r <= nw0_d;
    else rd_next_r <= next_mem[in_idx];
    if (pw1_en && (pw1_a == in_idx)) rd_prev_r <= pw1_d;
    else if (pw0_en && (pw0_a == in_idx)) rd_prev_r <= pw0_d;
    else rd_prev_r <= prev_mem[in_idx];
    out_status_r   <= status_nxt;
    out_new_slot_r <= to_field(new_slot_nxt);
    out_head_r     <= to_field(head_nxt);
    out_tail_r     <= to_field(tail_nxt);
  end

  assign out_valid    = out_valid_r;
  assign out_status   = out_status_r;
  assign out_new_slot = out_new_slot_r;
  assign out_head_out = out_head_r;
  assign out_tail_out = out_tail_r;

  `LLT_ASSERT_NXT(a_one_result_per_beat, vld_r, out_valid_r,
    "accepted command gave no result")
  `LLT_ASSERT_IMP(a_count_in_range, 1'b1, used_r <= FULL_CNT,
    "allocator count past table size")
  `LLT_ASSERT_IMP(a_refused_only_when_full,
    out_valid_r && (out_status_r == llt_pkg::ST_FULL), used_r == FULL_CNT,
    "insert refused with free slots left")
  `LLT_ASSERT_IMP(a_slot_only_on_done_insert,
    out_valid_r && (out_status_r != llt_pkg::ST_DONE),
    out_new_slot_r == llt_pkg::FIELD_NIL,
    "slot reported for a command that allocated none")
  `LLT_ASSERT_IMP(a_no_command_while_clearing, clr_r, !vld_r,
    "command taken during the clearing pass")

endmodule

// ===== tb/linked_line_table_checker.sv =====
// checker for the linked line table: predicts each list edit and compares result beats
// depends on llt_pkg; instantiated by linked_line_table_top_tb beside the block
`timescale 1ns / 1ps

module linked_line_table_checker #(
  parameter int ENTRIES = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic       busy,
  input  logic       in_op,
  input  logic [6:0] in_target,
  input  logic       out_valid,
  input  logic [1:0] out_status,
  input  logic [6:0] out_new_slot,
  input  logic [6:0] out_head_out,
  input  logic [6:0] out_tail_out,
  output int         fail_count,
  output int         views_pending
);

  localparam int NIL = -1;

  typedef struct packed {
    llt_pkg::status_t status;
    logic [6:0]       new_slot;
    logic [6:0]       head;
    logic [6:0]       tail;
  } list_view_t;

  int prev_of[ENTRIES];
  int next_of[ENTRIES];
  int head_ix;
  int tail_ix;
  int slots_used;
  int mismatches;
  list_view_t expected_views[$];

  function automatic bit in_table(input int ix);
    return ix >= 0 && ix < ENTRIES;
  endfunction

  function automatic void clear_list();
    for (int i = 0; i < ENTRIES; i++) begin
      prev_of[i] = NIL;
      next_of[i] = NIL;
    end
    head_ix = NIL;
    tail_ix = NIL;
    slots_used = 0;
  endfunction

  // applies one command to the shadow list and returns the view it should report
  function automatic list_view_t edit_list(input llt_pkg::op_t op, input logic [6:0] raw);
    int tgt;
    int slot;
    int after;
    int p;
    int n;
    list_view_t v;
    tgt = raw[6] ? int'(raw) - 128 : int'(raw);
    slot = NIL;
    v.status = llt_pkg::ST_DONE;
    if (op == llt_pkg::OP_INSERT) begin
      if (slots_used >= ENTRIES) begin
        v.status = llt_pkg::ST_FULL;
      end else begin
        slot = slots_used;
        slots_used++;
        if (head_ix == NIL) begin
          prev_of[slot] = NIL;
          next_of[slot] = NIL;
          head_ix = slot;
          tail_ix = slot;
        end else if (!in_table(tgt)) begin
          prev_of[slot] = tail_ix;
          next_of[slot] = NIL;
          if (in_table(tail_ix)) next_of[tail_ix] = slot;
          tail_ix = slot;
        end else begin
          after = next_of[tgt];
          prev_of[slot] = tgt;
          next_of[slot] = after;
          next_of[tgt] = slot;
          if (after == NIL) tail_ix = slot;
          else if (in_table(after)) prev_of[after] = slot;
        end
      end
    end else if (!in_table(tgt)) begin
      v.status = llt_pkg::ST_IGNORED;
    end else begin
      // links are followed as stored, even for a slot that is not on the list
      p = prev_of[tgt];
      n = next_of[tgt];
      if (p == NIL) head_ix = n;
      else if (in_table(p)) next_of[p] = n;
      if (n == NIL) tail_ix = p;
      else if (in_table(n)) prev_of[n] = p;
      next_of[tgt] = NIL;
      prev_of[tgt] = NIL;
    end
    v.new_slot = 7'(slot);
    v.head = 7'(head_ix);
    v.tail = 7'(tail_ix);
    return v;
  endfunction

  always @(posedge clk) begin
    list_view_t exp_view;
    if (!rst_n) begin
      clear_list();
      expected_views.delete();
      mismatches = 0;
    end else begin
      if (out_valid) begin
        if (expected_views.size() == 0) begin
          $error("result beat with no command waiting");
          mismatches++;
        end else begin
          exp_view = expected_views.pop_front();
          if (out_status !== exp_view.status) begin
            $error("status: expected %0d, got %0d", exp_view.status, out_status);
            mismatches++;
          end
          if (out_new_slot !== exp_view.new_slot) begin
            $error("new_slot: expected %0d, got %0d",
                   $signed(exp_view.new_slot), $signed(out_new_slot));
            mismatches++;
          end
          if (out_head_out !== exp_view.head) begin
            $error("head_out: expected %0d, got %0d",
                   $signed(exp_view.head), $signed(out_head_out));
            mismatches++;
          end
          if (out_tail_out !== exp_view.tail) begin
            $error("tail_out: expected %0d, got %0d",
                   $signed(exp_view.tail), $signed(out_tail_out));
            mismatches++;
          end
        end
      end
      if (start && !busy) begin
        expected_views.push_back(edit_list(llt_pkg::op_t'(in_op), in_target));
      end
    end
    fail_count <= mismatches;
    views_pending <= expected_views.size();
  end

endmodule

// ===== tb/linked_line_table_top_tb.sv =====
// testbench top for the linked line table: clock, reset, command stimulus and verdict
// depends on llt_pkg, linked_line_table_top and linked_line_table_checker
`timescale 1ns / 1ps

module linked_line_table_top_tb;

  localparam int ENTRIES = 64;
  localparam int EDITS = 1525;

  logic       clk;
  logic       rst_n;
  logic       start;
  logic       busy;
  logic       in_op;
  logic [6:0] in_target;
  logic       out_valid;
  logic [1:0] out_status;
  logic [6:0] out_new_slot;
  logic [6:0] out_head_out;
  logic [6:0] out_tail_out;
  int         fail_count;
  int         views_pending;

  // rough shadow of which slots are on the list, only to steer targets
  bit on_list[ENTRIES];
  int slots_given;
  int burst_left;

  linked_line_table_top #(.ENTRIES(ENTRIES)) u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .start       (start),
    .busy        (busy),
    .in_op       (in_op),
    .in_target   (in_target),
    .out_valid   (out_valid),
    .out_status  (out_status),
    .out_new_slot(out_new_slot),
    .out_head_out(out_head_out),
    .out_tail_out(out_tail_out)
  );

  linked_line_table_checker #(.ENTRIES(ENTRIES)) u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .in_op        (in_op),
    .in_target    (in_target),
    .out_valid    (out_valid),
    .out_status   (out_status),
    .out_new_slot (out_new_slot),
    .out_head_out (out_head_out),
    .out_tail_out (out_tail_out),
    .fail_count   (fail_count),
    .views_pending(views_pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #2000000;
    $display("FAILURE");
    $finish;
  end

  // one command beat; a new burst starts after a random gap, which may be zero
  task automatic issue(input llt_pkg::op_t op, input logic [6:0] tgt);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        start <= 1'b0;
        in_op <= 1'($urandom_range(1));
        in_target <= 7'($urandom);
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    start <= 1'b1;
    in_op <= op;
    in_target <= tgt;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (op == llt_pkg::OP_INSERT) begin
      if (slots_given < ENTRIES) begin
        on_list[slots_given] = 1'b1;
        slots_given++;
      end
    end else if (!tgt[6]) begin
      on_list[tgt] = 1'b0;
    end
  endtask

  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (views_pending != 0) @(posedge clk);
    burst_left = 0;
  endtask

  function automatic int live_slot();
    int c;
    if (slots_given == 0) return -1;
    for (int i = 0; i < 8; i++) begin
      c = $urandom_range(slots_given - 1);
      if (on_list[c]) return c;
    end
    return -1;
  endfunction

  initial begin
    int r;
    int t;
    int counted;
    bit mid_drained;
    rst_n <= 1'b0;
    start <= 1'b0;
    in_op <= llt_pkg::OP_INSERT;
    in_target <= '0;
    slots_given = 0;
    burst_left = 0;
    counted = 0;
    mid_drained = 1'b0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: empty list, appends, inserts after live and dead entries, odd targets
    issue(llt_pkg::OP_DELETE, 7'd5);
    issue(llt_pkg::OP_DELETE, 7'h7F);
    issue(llt_pkg::OP_DELETE, 7'h40);
    issue(llt_pkg::OP_INSERT, 7'd21);
    issue(llt_pkg::OP_INSERT, 7'h7F);
    issue(llt_pkg::OP_INSERT, 7'd0);
    issue(llt_pkg::OP_INSERT, 7'h40);
    issue(llt_pkg::OP_INSERT, 7'h7E);
    issue(llt_pkg::OP_INSERT, 7'd4);
    issue(llt_pkg::OP_INSERT, 7'd63);
    issue(llt_pkg::OP_DELETE, 7'd2);
    issue(llt_pkg::OP_DELETE, 7'd0);
    issue(llt_pkg::OP_DELETE, 7'd6);
    // deleting a slot already off the list collapses head and tail
    issue(llt_pkg::OP_DELETE, 7'd2);
    issue(llt_pkg::OP_INSERT, 7'h7F);
    issue(llt_pkg::OP_INSERT, 7'd7);
    issue(llt_pkg::OP_DELETE, 7'd7);
    issue(llt_pkg::OP_DELETE, 7'd8);
    issue(llt_pkg::OP_DELETE, 7'd63);
    issue(llt_pkg::OP_DELETE, 7'h3F);
    drain();

    while (counted < EDITS) begin
      if (!mid_drained && counted >= EDITS / 2) begin
        drain();
        mid_drained = 1'b1;
      end
      r = $urandom_range(99);
      if (r < 45) begin
        t = $urandom_range(9);
        if (t < 5) t = live_slot();
        else if (t < 8) t = -1;
        else t = $urandom_range(127);
        issue(llt_pkg::OP_INSERT, 7'(t));
      end else if (r < 75) begin
        t = live_slot();
        if (t < 0) begin
          issue(llt_pkg::OP_DELETE, 7'($urandom_range(64, 127)));
        end else begin
          issue(llt_pkg::OP_DELETE, 7'(t));
        end
      end else if (r < 78) begin
        issue(llt_pkg::OP_DELETE, 7'($urandom_range(ENTRIES - 1)));
      end else begin
        // out-of-range delete, the block only reports it
        issue(llt_pkg::OP_DELETE, 7'($urandom_range(64, 127)));
      end
      counted++;
    end

    drain();
    repeat (4) @(posedge clk);
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
